### src/ssv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssv_pkg: shared types and constants of the step sequencer sine voice
// Item layouts of both channels, the step table entry and the fixed-point
// constants of the sine polynomial and the serial arithmetic.
// ----------------------------------------------------------------------------
package ssv_pkg;

    // input item op codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // field widths
    localparam int LC_W   = 24;
    localparam int VEL_W  = 9;
    localparam int INCR_W = 24;
    localparam int OUT_STEP_W = 4;

    // velocity of one, written velocities above it saturate
    localparam logic [VEL_W-1:0] VEL_ONE = 9'd256;

    // reset value of the step length
    localparam logic [LC_W-1:0] SPS_RESET = 24'd6000;

    // sine polynomial coefficients, Q16
    localparam logic [16:0] SIN_A = 17'd102944;
    localparam logic [15:0] SIN_B = 16'd42048;
    localparam logic [12:0] SIN_C = 13'd4640;
    localparam logic [16:0] X_ONE = 17'd65536;
    localparam logic [15:0] MAG_MAX = 16'd32767;

    // serial multiplier: multiplicand width, product register width
    localparam int MC_W   = 24;
    localparam int PROD_W = 48;

    // iteration counts of the serial units
    localparam int CNT_W = 5;
    localparam logic [CNT_W-1:0] N_PHASE = 5'd24;
    localparam logic [CNT_W-1:0] N_POLY  = 5'd17;
    localparam logic [CNT_W-1:0] N_VEL   = 5'd9;
    localparam logic [CNT_W-1:0] N_SCALE = 5'd24;
    localparam logic [CNT_W-1:0] N_DIV   = 5'd15;

    typedef struct packed {
        logic                op;
        logic [3:0]          step_slot;
        logic                step_active;
        logic [VEL_W-1:0]    step_velocity;
        logic [INCR_W-1:0]   step_phase_incr;
        logic                restart;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0]      sample;
        logic [OUT_STEP_W-1:0]   current_step;
    } t_out_item;

    typedef struct packed {
        logic                active;
        logic [VEL_W-1:0]    velocity;
        logic [INCR_W-1:0]   incr;
    } t_step;

endpackage
`default_nettype wire

### src/step_sequencer_sine_voice.sv
`timescale 1ns / 1ps
`default_nettype none
// Flow: a write item leaves the block idle; a tick passes S_READ and S_START, then
//   S_OUT on an inactive step, or S_PHASE through S_DIV before S_OUT on an active one.
// Input: stalled until a tick's sample is in the output register, so one tick at a time;
//   the work is the shift-add multiplier (one bit per cycle, seven products) and 15-bit divider.
// Reset: synchronous; clears the step valid bits, position, count and output
//   valid, and loads the step length with 6000. No clearing pass.
// ----------------------------------------------------------------------------
// step_sequencer_sine_voice: sixteen step sequencer with a sine voice
// Holds a table of steps, renders one sample per tick from the current step
// with bit-serial arithmetic, and advances through the steps over time.
// ----------------------------------------------------------------------------
module step_sequencer_sine_voice
    import ssv_pkg::*;
#(
    parameter int STEPS          = 16,
    parameter int SINE_ADDR_BITS = 10
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_in_valid,
    input  wire t_in_item    i_in_data,
    output logic             o_in_stall,
    // output channel
    output logic             o_out_valid,
    output t_out_item        o_out_data,
    input  wire logic        i_out_stall,
    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int PW    = $clog2(STEPS);
    localparam int QBITS = SINE_ADDR_BITS - 2;
    localparam int XSH   = 16 - QBITS;

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_START, S_PHASE, S_X2, S_T1, S_T3, S_Y,
        S_MV, S_SCALE, S_DIV, S_OUT
    } t_state;

    // control registers
    t_state              r_state, n_state;
    logic [LC_W-1:0]     r_sps, n_sps;
    logic [LC_W-1:0]     r_lc, n_lc;
    logic [PW-1:0]       r_pos, n_pos;
    logic [STEPS-1:0]    r_vld, n_vld;
    logic                r_rd_vld;
    logic                r_out_valid, n_out_valid;
    logic [CNT_W-1:0]    r_cnt, n_cnt;

    // datapath registers
    t_out_item           r_out, n_out;
    t_step               r_rd_entry;
    logic [PROD_W-1:0]   r_prod, n_prod;
    logic [MC_W-1:0]     r_mcand, n_mcand;
    logic [16:0]         r_x, n_x;
    logic [16:0]         r_x2, n_x2;
    logic [1:0]          r_quad, n_quad;
    logic                r_neg, n_neg;
    logic [LC_W-1:0]     r_rem, n_rem;
    logic [14:0]         r_dq, n_dq;

    // step table
    t_step               mem [STEPS];
    logic                wr_en;
    logic [PW-1:0]       wr_addr;
    t_step               wr_entry;

    // combinational helpers
    logic                in_xfer, cfg_wr, last;
    logic [LC_W-1:0]     sps_eff;
    logic [LC_W-1:0]     a_lc;
    logic [PW-1:0]       a_pos;
    logic [LC_W-1:0]     lc_inc;
    logic [PROD_W-1:0]   p_nx;
    logic [SINE_ADDR_BITS-1:0] s_addr;
    logic [1:0]          s_quad;
    logic [16:0]         s_xu, s_x;
    logic [16:0]         x2_w, t4_w, y_w, y1_w;
    logic [12:0]         t1_w;
    logic [15:0]         t2_w, t3_w, yh_w;
    logic [14:0]         mag_w;
    logic [22:0]         mv_w;
    logic [38:0]         nd_w;
    logic [LC_W:0]       d_r2, d_sub;
    logic                d_ge;
    logic [15:0]         q_ext;

    // one shift-add step: add multiplicand on the low multiplier bit, shift right
    function automatic logic [PROD_W-1:0] mult_step(input logic [PROD_W-1:0] p,
                                                    input logic [MC_W-1:0] mc);
        logic [MC_W:0] s;
        s = {1'b0, p[PROD_W-1:MC_W]} + (p[0] ? {1'b0, mc} : {(MC_W+1){1'b0}});
        return {s, p[MC_W-1:1]};
    endfunction

    // next step position, wrapping at the table size
    function automatic logic [PW-1:0] pos_next(input logic [PW-1:0] p);
        return (p == PW'(STEPS - 1)) ? '0 : PW'(p + PW'(1));
    endfunction

    // handshakes and register port
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign pready      = 1'b1;
    assign cfg_wr      = psel && penable && pwrite && (paddr == 3'd0);
    assign prdata      = (paddr == 3'd0) ? {8'd0, r_sps} : 32'd0;

    // zero step length acts as one
    assign sps_eff = (r_sps == '0) ? LC_W'(1) : r_sps;

    // time at a tick transfer: restart, then skip past a shortened step
    assign a_lc  = i_in_data.restart ? '0 : r_lc;
    assign a_pos = i_in_data.restart ? '0 : r_pos;
    assign lc_inc = r_lc + LC_W'(1);

    // step table write with velocity saturation
    assign wr_en    = in_xfer && (i_in_data.op == OP_WRITE)
                      && (32'(i_in_data.step_slot) < 32'(STEPS));
    assign wr_addr  = PW'(i_in_data.step_slot);
    assign wr_entry = '{active:   i_in_data.step_active,
                        velocity: (i_in_data.step_velocity > VEL_ONE) ?
                                  VEL_ONE : i_in_data.step_velocity,
                        incr:     i_in_data.step_phase_incr};

    // shared serial multiplier
    assign p_nx = mult_step(r_prod, r_mcand);
    assign last = (r_cnt == CNT_W'(1));

    // sine address from the phase, folded into the first quadrant
    assign s_addr = p_nx[23 -: SINE_ADDR_BITS];
    assign s_quad = s_addr[SINE_ADDR_BITS-1 -: 2];
    assign s_xu   = 17'(s_addr[QBITS-1:0]) << XSH;
    assign s_x    = s_quad[0] ? (X_ONE - s_xu) : s_xu;

    // polynomial terms taken from the product after its last step
    assign x2_w  = p_nx[39:23];
    assign t1_w  = p_nx[35:23];
    assign t2_w  = SIN_B - {3'd0, t1_w};
    assign t3_w  = p_nx[38:23];
    assign t4_w  = SIN_A - {1'b0, t3_w};
    assign y_w   = p_nx[39:23];
    assign y1_w  = y_w + 17'd1;
    assign yh_w  = y1_w[16:1];
    assign mag_w = (yh_w > MAG_MAX) ? MAG_MAX[14:0] : yh_w[14:0];
    assign mv_w  = p_nx[37:15];
    assign nd_w  = p_nx[46:8];

    // restoring division step by the step length
    assign d_r2  = {r_rem, r_dq[14]};
    assign d_ge  = (d_r2 >= {1'b0, sps_eff});
    assign d_sub = d_r2 - {1'b0, sps_eff};
    assign q_ext = {1'b0, r_dq};

    // next state and datapath
    always_comb begin
        n_state     = r_state;
        n_sps       = cfg_wr ? pwdata[LC_W-1:0] : r_sps;
        n_lc        = r_lc;
        n_pos       = r_pos;
        n_vld       = r_vld;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        n_cnt       = r_cnt;
        n_prod      = r_prod;
        n_mcand     = r_mcand;
        n_x         = r_x;
        n_x2        = r_x2;
        n_quad      = r_quad;
        n_neg       = r_neg;
        n_rem       = r_rem;
        n_dq        = r_dq;

        if (wr_en) begin
            n_vld[wr_addr] = 1'b1;
        end

        case (r_state)
            S_IDLE: begin
                if (in_xfer && (i_in_data.op == OP_TICK)) begin
                    if (a_lc >= sps_eff) begin
                        n_lc  = '0;
                        n_pos = pos_next(a_pos);
                    end else begin
                        n_lc  = a_lc;
                        n_pos = a_pos;
                    end
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_START;
            end
            S_START: begin
                if (r_rd_vld && r_rd_entry.active) begin
                    n_mcand = r_rd_entry.incr;
                    n_prod  = {{MC_W{1'b0}}, r_lc};
                    n_cnt   = N_PHASE;
                    n_state = S_PHASE;
                end else begin
                    n_dq    = '0;
                    n_neg   = 1'b0;
                    n_state = S_OUT;
                end
            end
            S_PHASE: begin
                n_prod = p_nx;
                n_cnt  = r_cnt - CNT_W'(1);
                if (last) begin
                    n_x     = s_x;
                    n_quad  = s_quad;
                    n_mcand = MC_W'(s_x);
                    n_prod  = {{MC_W{1'b0}}, MC_W'(s_x)};
                    n_cnt   = N_POLY;
                    n_state = S_X2;
                end
            end
            S_X2: begin
                n_prod = p_nx;
                n_cnt  = r_cnt - CNT_W'(1);
                if (last) begin
                    n_x2    = x2_w;
                    n_mcand = MC_W'(SIN_C);
                    n_prod  = {{MC_W{1'b0}}, MC_W'(x2_w)};
                    n_cnt   = N_POLY;
                    n_state = S_T1;
                end
            end
            S_T1: begin
                n_prod = p_nx;
                n_cnt  = r_cnt - CNT_W'(1);
                if (last) begin
                    n_mcand = MC_W'(t2_w);
                    n_prod  = {{MC_W{1'b0}}, MC_W'(r_x2)};
                    n_cnt   = N_POLY;
                    n_state = S_T3;
                end
            end
            S_T3: begin
                n_prod = p_nx;
                n_cnt  = r_cnt - CNT_W'(1);
                if (last) begin
                    n_mcand = MC_W'(t4_w);
                    n_prod  = {{MC_W{1'b0}}, MC_W'(r_x)};
                    n_cnt   = N_POLY;
                    n_state = S_Y;
                end
            end
            S_Y: begin
                n_prod = p_nx;
                n_cnt  = r_cnt - CNT_W'(1);
                if (last) begin
                    n_neg   = r_quad[1];
                    n_mcand = MC_W'(mag_w);
                    n_prod  = {{MC_W{1'b0}}, MC_W'(r_rd_entry.velocity)};
                    n_cnt   = N_VEL;
                    n_state = S_MV;
                end
            end
            S_MV: begin
                n_prod = p_nx;
                n_cnt  = r_cnt - CNT_W'(1);
                if (last) begin
                    n_mcand = MC_W'(mv_w);
                    n_prod  = {{MC_W{1'b0}}, sps_eff - r_lc};
                    n_cnt   = N_SCALE;
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                n_prod = p_nx;
                n_cnt  = r_cnt - CNT_W'(1);
                if (last) begin
                    n_rem   = nd_w[38:15];
                    n_dq    = nd_w[14:0];
                    n_cnt   = N_DIV;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_rem = d_ge ? d_sub[LC_W-1:0] : d_r2[LC_W-1:0];
                n_dq  = {r_dq[13:0], d_ge};
                n_cnt = r_cnt - CNT_W'(1);
                if (last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                // wait for the output register, then advance time
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid         = 1'b1;
                    n_out.sample        = r_neg ? (16'd0 - q_ext) : q_ext;
                    n_out.current_step  = OUT_STEP_W'(r_pos);
                    if (lc_inc >= sps_eff) begin
                        n_lc  = '0;
                        n_pos = pos_next(r_pos);
                    end else begin
                        n_lc  = lc_inc;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state, control and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sps       <= SPS_RESET;
            r_lc        <= '0;
            r_pos       <= '0;
            r_vld       <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_sps       <= n_sps;
            r_lc        <= n_lc;
            r_pos       <= n_pos;
            r_vld       <= n_vld;
            r_rd_vld    <= r_vld[r_pos];
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
        end
    end

    // datapath and output payload
    always_ff @(posedge i_clk) begin
        r_out   <= n_out;
        r_prod  <= n_prod;
        r_mcand <= n_mcand;
        r_x     <= n_x;
        r_x2    <= n_x2;
        r_quad  <= n_quad;
        r_neg   <= n_neg;
        r_rem   <= n_rem;
        r_dq    <= n_dq;
    end

    // step table memory, registered read at the current position
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_entry;
        end
        r_rd_entry <= mem[r_pos];
    end

endmodule
`default_nettype wire

### src/ssv_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssv_checker: port-level checks of the step sequencer sine voice
// Watches the channel handshakes and the sample range over time.
// ----------------------------------------------------------------------------
module ssv_checker
    import ssv_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire t_in_item  i_in_data,
    input wire logic      o_in_stall,
    input wire logic      o_out_valid,
    input wire t_out_item o_out_data,
    input wire logic      i_out_stall
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled output changed");

    // a tick transfer busies the block for the following cycle
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_in_data.op == OP_TICK)) |=> o_in_stall)
        else $error("tick transfer did not start work");

    // a step write leaves the input free in the cycle after it
    a_write_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_in_data.op == OP_WRITE)) |=> !o_in_stall)
        else $error("step write held the input");

    // the sample never reaches the most negative code
    a_sample_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.sample != 16'sh8000))
        else $error("sample out of range");

endmodule

bind step_sequencer_sine_voice ssv_checker u_ssv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_data   (i_in_data),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);
`default_nettype wire
